[sv/bcdd_pkg.sv]
// shared constants and types for the button click detector
`default_nettype none

package bcdd_pkg;

    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int WINDOW_WIDTH      = 8;
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 8'd50;

    localparam int EVENT_WIDTH = 2;
    typedef logic [EVENT_WIDTH-1:0] click_event_t;

    localparam click_event_t EVT_NONE   = 2'd0;
    localparam click_event_t EVT_SINGLE = 2'd1;
    localparam click_event_t EVT_DOUBLE = 2'd2;

    localparam int TALLY_WIDTH = 2;
    typedef logic [TALLY_WIDTH-1:0] tally_t;

    localparam tally_t TALLY_ZERO = 2'd0;
    localparam tally_t TALLY_ONE  = 2'd1;
    localparam tally_t TALLY_TWO  = 2'd2;
    localparam tally_t TALLY_BAD  = 2'd3;

    localparam int IN_TDATA_WIDTH  = 8;
    localparam int OUT_TDATA_WIDTH = 8;

endpackage

`default_nettype wire

[sv/bcdd_in_stage.sv]
// input register holding one sampled key level
`default_nettype none

module bcdd_in_stage (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire logic key_level_in,
    input  wire logic advance,
    output logic      item_valid,
    output logic      key_level
);
    logic valid_reg;
    logic valid_next;
    logic key_reg;

    // room when empty or when the held item moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign valid_next = s_tvalid || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            key_reg <= key_level_in;
        end
    end

    assign item_valid = valid_reg;
    assign key_level  = key_reg;

endmodule

`default_nettype wire

[sv/bcdd_core.sv]
// click classification state and per-tick update
`default_nettype none

module bcdd_core #(
    parameter int COUNTER_WIDTH = bcdd_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_write,
    input  wire logic [bcdd_pkg::WINDOW_WIDTH-1:0]  cfg_window,
    input  wire logic                               advance,
    input  wire logic                               key_level,
    output bcdd_pkg::click_event_t                  click_event
);
    import bcdd_pkg::*;

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    logic [WINDOW_WIDTH-1:0]  window_reg;
    logic                     armed_reg, armed_next;
    logic                     counted_reg, counted_next;
    tally_t                   tally_reg, tally_next;
    logic [COUNTER_WIDTH-1:0] gap_reg, gap_next;
    logic [COUNTER_WIDTH-1:0] hold_reg, hold_next;

    logic                     pressed;
    logic                     armed_mid;
    logic                     counted_mid;
    tally_t                   tally_mid;
    logic [COUNTER_WIDTH-1:0] gap_inc;
    logic [COUNTER_WIDTH-1:0] win_ext;
    click_event_t             event_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_write) begin
            window_reg <= cfg_window;
        end
    end

    assign pressed = !key_level;
    assign win_ext = {{(COUNTER_WIDTH-WINDOW_WIDTH){1'b0}}, window_reg};
    assign gap_inc = (gap_reg == CNT_MAX) ? CNT_MAX : gap_reg + 1'b1;

    always_comb begin
        hold_next    = pressed ? ((hold_reg == CNT_MAX) ? CNT_MAX : hold_reg + 1'b1)
                               : '0;
        armed_mid    = armed_reg || pressed;
        counted_mid  = counted_reg;
        tally_mid    = tally_reg;
        armed_next   = armed_mid;
        counted_next = counted_reg;
        tally_next   = tally_reg;
        gap_next     = gap_reg;
        event_c      = EVT_NONE;

        // count a fresh press once
        if (!counted_reg && armed_mid) begin
            tally_mid   = tally_reg + 1'b1;
            counted_mid = 1'b1;
        end

        if (!counted_reg && tally_mid == TALLY_TWO) begin
            // double click, both flags stay set on this tick even on release
            tally_next   = TALLY_ZERO;
            gap_next     = '0;
            counted_next = counted_mid;
            event_c      = EVT_DOUBLE;
        end else begin
            armed_next   = pressed ? armed_mid : 1'b0;
            counted_next = pressed ? counted_mid : 1'b0;
            tally_next   = tally_mid;
            if (tally_mid == TALLY_ONE) begin
                gap_next = gap_inc;
                if (gap_inc > win_ext && hold_next < win_ext) begin
                    tally_next = TALLY_ZERO;
                    gap_next   = '0;
                    event_c    = EVT_SINGLE;
                end else if (hold_next > win_ext) begin
                    // held too long, drop the pending click
                    tally_next = TALLY_ZERO;
                    gap_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg   <= 1'b0;
            counted_reg <= 1'b0;
            tally_reg   <= TALLY_ZERO;
            gap_reg     <= '0;
            hold_reg    <= '0;
        end else if (advance) begin
            armed_reg   <= armed_next;
            counted_reg <= counted_next;
            tally_reg   <= tally_next;
            gap_reg     <= gap_next;
            hold_reg    <= hold_next;
        end
    end

    assign click_event = event_c;

`ifndef NO_ASSERTIONS
    a_tally_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg != TALLY_BAD)
        else $error("press tally reached three");

    a_counted_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        counted_reg |-> armed_reg)
        else $error("press counted without being armed");

    a_single_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && event_c == EVT_SINGLE) |=> (tally_reg == TALLY_ZERO && gap_reg == '0))
        else $error("single click left a pending sequence");

    a_release_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && key_level) |=> (hold_reg == '0))
        else $error("hold count not cleared on release");
`endif

endmodule

`default_nettype wire

[sv/bcdd_out_stage.sv]
// result register toward the output stream
`default_nettype none

module bcdd_out_stage (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   item_valid,
    input  wire bcdd_pkg::click_event_t click_event,
    output logic                        advance,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output bcdd_pkg::click_event_t      click_event_out
);
    import bcdd_pkg::*;

    logic         valid_reg;
    click_event_t event_reg;

    // take a new result when empty or when the held one is being taken
    assign advance = item_valid && (!valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            event_reg <= click_event;
        end
    end

    assign m_tvalid        = valid_reg;
    assign click_event_out = event_reg;

endmodule

`default_nettype wire

[sv/button_click_double_click_detector_top.sv]
// top level of the button single / double click detector
`default_nettype none

// Classifies one sampled button level per request (0 pressed, 1 released) into
// no action, single click or double click, one result per input request. A
// second counted press gives a double click at once; a first press released
// early gives a single click once the gap passes click_window ticks; a press
// held past the window drops the pending click. Gap and hold counters are
// COUNTER_WIDTH bits and saturate. Throughput is one request per clock unless
// m_tready is held low: the sample sits in an input register, the state
// update is one short combinational step, and the result lands in an output
// register when it has room, raising m_tvalid. Back-pressure on m_tready
// stalls the result register and, through it, the input register. The
// click_window (reset 50) is written on the cfg channel, which is always
// ready, and should only change while no request is in flight.
module button_click_double_click_detector_top #(
    parameter int COUNTER_WIDTH = bcdd_pkg::COUNTER_WIDTH_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // input stream
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [bcdd_pkg::IN_TDATA_WIDTH-1:0]    s_tdata,  // [0] key_level, rest zero
    // result stream
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [bcdd_pkg::OUT_TDATA_WIDTH-1:0]        m_tdata,  // [1:0] click_event, rest zero
    // configuration write
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [bcdd_pkg::WINDOW_WIDTH-1:0]      cfg_data  // click_window
);
    import bcdd_pkg::*;

    logic         advance;
    logic         item_valid;
    logic         key_level;
    click_event_t event_c;
    click_event_t event_out;

    // register write always taken
    assign cfg_ready = 1'b1;

    // input register
    bcdd_in_stage u_in (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .key_level_in (s_tdata[0]),
        .advance      (advance),
        .item_valid   (item_valid),
        .key_level    (key_level)
    );

    // state and classification
    bcdd_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_window  (cfg_data),
        .advance     (advance),
        .key_level   (key_level),
        .click_event (event_c)
    );

    // result register
    bcdd_out_stage u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (item_valid),
        .click_event     (event_c),
        .advance         (advance),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .click_event_out (event_out)
    );

    assign m_tdata = {{(OUT_TDATA_WIDTH-EVENT_WIDTH){1'b0}}, event_out};

endmodule

`default_nettype wire
